@@ hw/rtl/ogfc_pkg.sv @@
package ogfc_pkg;

  // Default grid store size
  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned MAX_COLS_DEF = 256;

  // Field and register widths
  localparam int unsigned VAL_W       = 8;
  localparam int unsigned SZ_W        = 9;
  localparam int unsigned TH_W        = 7;
  localparam int unsigned CNT_OUT_W   = 17;
  localparam int unsigned CMP_W       = 13;
  localparam int unsigned NBR_CNT_W   = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  // Reset values
  localparam logic [SZ_W-1:0] DEF_ROWS = SZ_W'(20);
  localparam logic [SZ_W-1:0] DEF_COLS = SZ_W'(20);
  localparam logic [TH_W-1:0] DEF_FREE = TH_W'(20);
  localparam logic [TH_W-1:0] DEF_OCC  = TH_W'(80);

  localparam logic [VAL_W-1:0] NO_DATA = 8'hFF;
  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = '1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_FREE = 2'd2,
    REG_OCC  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_FREE = 2'd0,
    CLS_OCC  = 2'd1,
    CLS_UNK  = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    STEP_ZERO = 2'd0,
    STEP_DEC  = 2'd1,
    STEP_INC  = 2'd2
  } step_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RECOUNT,
    ST_IDLE,
    ST_ADDR,
    ST_CRD,
    ST_CDAT,
    ST_NBR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [SZ_W-1:0] rows;
    logic [SZ_W-1:0] cols;
    logic [TH_W-1:0] free_th;
    logic [TH_W-1:0] occ_th;
  } cfg_regs_t;

  typedef struct packed {
    logic size_wr;
    logic th_wr;
  } cfg_evt_t;

  // Cell class from value and thresholds; free wins over occupied
  function automatic cls_e classify(logic [VAL_W-1:0] v, logic [TH_W-1:0] fth,
                                    logic [TH_W-1:0] oth);
    cls_e c;
    if (v == NO_DATA) begin
      c = CLS_UNK;
    end else if (v < VAL_W'(fth)) begin
      c = CLS_FREE;
    end else if (v > VAL_W'(oth)) begin
      c = CLS_OCC;
    end else begin
      c = CLS_UNK;
    end
    return c;
  endfunction

  // Neighbor order: row above left to right, left, right, row below
  function automatic step_e nbr_row_step(logic [2:0] k);
    step_e s;
    case (k)
      3'd0, 3'd1, 3'd2: s = STEP_DEC;
      3'd3, 3'd4:       s = STEP_ZERO;
      3'd5, 3'd6, 3'd7: s = STEP_INC;
      default:          s = STEP_ZERO;
    endcase
    return s;
  endfunction

  function automatic step_e nbr_col_step(logic [2:0] k);
    step_e s;
    case (k)
      3'd0, 3'd3, 3'd5: s = STEP_DEC;
      3'd1, 3'd6:       s = STEP_ZERO;
      3'd2, 3'd4, 3'd7: s = STEP_INC;
      default:          s = STEP_ZERO;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/occupancy_grid_frontier_check.sv @@
// A beat passes the address and center read steps; an in-range cell then takes the
// center data step, and a free cell reads its eight neighbors through the single RAM
// port. Items are taken only when idle; the next beat is taken while a result waits.
// Reset: a clearing pass writes no-data over the grid in use, rows*cols cells (400 at
// reset values), with tready low. A size write repeats it; a threshold write outside a
// clearing pass starts a recount sweep. A register write aborts any item in progress.
module occupancy_grid_frontier_check #(
  parameter int unsigned MAX_ROWS = ogfc_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = ogfc_pkg::MAX_COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // row[15:0], col[31:16], cell_value[39:32]
  input  logic [ogfc_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // kind[0]
  input  logic [0:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // in_range[0], cell_class[2:1], is_frontier[3], unknown_count[20:4], zero[23:21]
  output logic [ogfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ogfc_pkg::APB_AW-1:0]       paddr,
  input  logic [ogfc_pkg::APB_DW-1:0]       pwdata,
  output logic [ogfc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  import ogfc_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfg_regs_t regs;
  cfg_evt_t  evt;

  state_e               state_q, state_d;
  logic [ROW_W-1:0]     sw_r_q, sw_r_d;
  logic [COL_W-1:0]     sw_c_q, sw_c_d;
  logic [AW-1:0]        sw_base_q, sw_base_d;
  logic [NBR_CNT_W-1:0] nbr_q, nbr_d;
  logic                 n_pend_q, n_pend_d;
  logic                 rc_pend_q, rc_pend_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovalid_q, ovalid_d;

  logic                 kind_q;
  logic [15:0]          row_q, col_q;
  logic [VAL_W-1:0]     val_q;
  logic [AW-1:0]        ctr_addr_q, ctr_addr_d;
  logic                 inr_q, inr_d;
  cls_e                 cls_q, cls_d;
  logic                 front_q, front_d;
  logic [OUT_TDATA_W-1:0] out_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [VAL_W-1:0]     ram_wdata, ram_rdata;
  logic [AW-1:0]        nbr_addr, sw_addr;
  logic                 nbr_ok;
  logic                 c_last, r_last, sw_last;
  logic                 in_beat, load_out;
  logic                 rd_unk, old_unk, new_unk;
  logic [CNT_OUT_W-1:0] cnt_sat;

  ogfc_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs_o  (regs),
    .evt_o   (evt)
  );

  ogfc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  ogfc_nbr_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_nbr (
    .ctr_addr_i (ctr_addr_q),
    .row_i      (row_q[ROW_W-1:0]),
    .col_i      (col_q[COL_W-1:0]),
    .rows_i     (regs.rows),
    .cols_i     (regs.cols),
    .k_i        (nbr_q[2:0]),
    .addr_o     (nbr_addr),
    .ok_o       (nbr_ok)
  );

  // Sweep position over the grid in use
  assign sw_addr = sw_base_q + AW'(sw_c_q);
  assign c_last  = (CMP_W'(sw_c_q) + CMP_W'(1)) == CMP_W'(regs.cols);
  assign r_last  = (CMP_W'(sw_r_q) + CMP_W'(1)) == CMP_W'(regs.rows);
  assign sw_last = c_last & r_last;

  assign rd_unk  = (classify(ram_rdata, regs.free_th, regs.occ_th) == CLS_UNK);
  assign old_unk = rd_unk;
  assign new_unk = (classify(val_q, regs.free_th, regs.occ_th) == CLS_UNK);

  // No beat taken in a cycle with a register write
  assign s_axis_tready_o = (state_q == ST_IDLE) & ~evt.size_wr & ~evt.th_wr;
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;

  // Saturated count for the result
  always_comb begin
    if (32'(cnt_q) > 32'(CNT_OUT_MAX)) begin
      cnt_sat = CNT_OUT_MAX;
    end else begin
      cnt_sat = CNT_OUT_W'(cnt_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    sw_r_d     = sw_r_q;
    sw_c_d     = sw_c_q;
    sw_base_d  = sw_base_q;
    nbr_d      = nbr_q;
    n_pend_d   = 1'b0;
    rc_pend_d  = 1'b0;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_addr   = sw_addr;
    ram_wdata  = NO_DATA;
    ctr_addr_d = ctr_addr_q;
    inr_d      = inr_q;
    cls_d      = cls_q;
    front_d    = front_q;
    load_out   = 1'b0;

    // Recount: data of the read issued last cycle
    if (rc_pend_q && rd_unk) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    case (state_q)
      ST_CLEAR, ST_RECOUNT: begin
        if (state_q == ST_CLEAR) begin
          ram_we    = 1'b1;
          ram_wdata = NO_DATA;
          cnt_d     = cnt_q + CNT_W'(1);
        end else begin
          rc_pend_d = 1'b1;
        end
        if (c_last) begin
          sw_c_d    = '0;
          sw_r_d    = sw_r_q + ROW_W'(1);
          sw_base_d = sw_base_q + AW'(MAX_COLS);
        end else begin
          sw_c_d = sw_c_q + COL_W'(1);
        end
        if (sw_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        inr_d = ~row_q[15] & ~col_q[15] & (row_q[14:0] < 15'(regs.rows)) &
                (col_q[14:0] < 15'(regs.cols));
        ctr_addr_d = AW'(row_q[ROW_W-1:0]) * AW'(MAX_COLS) + AW'(col_q[COL_W-1:0]);
        cls_d      = CLS_UNK;
        front_d    = 1'b0;
        state_d    = ST_CRD;
      end
      ST_CRD: begin
        ram_addr = ctr_addr_q;
        state_d  = inr_q ? ST_CDAT : ST_DONE;
      end
      ST_CDAT: begin
        ram_addr = ctr_addr_q;
        if (kind_q == KIND_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = val_q;
          cnt_d     = cnt_q - CNT_W'(old_unk) + CNT_W'(new_unk);
          cls_d     = classify(val_q, regs.free_th, regs.occ_th);
        end else begin
          cls_d = classify(ram_rdata, regs.free_th, regs.occ_th);
        end
        if (cls_d == CLS_FREE) begin
          nbr_d   = '0;
          state_d = ST_NBR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NBR: begin
        ram_addr = nbr_addr;
        if (n_pend_q && rd_unk) begin
          front_d = 1'b1;
        end
        if (nbr_q[NBR_CNT_W-1]) begin
          state_d = ST_DONE;
        end else begin
          n_pend_d = nbr_ok;
          nbr_d    = nbr_q + NBR_CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Register writes restart the sweeps
    if (evt.size_wr) begin
      state_d   = ST_CLEAR;
      sw_r_d    = '0;
      sw_c_d    = '0;
      sw_base_d = '0;
      cnt_d     = '0;
      rc_pend_d = 1'b0;
    end else if (evt.th_wr && state_q != ST_CLEAR) begin
      state_d   = ST_RECOUNT;
      sw_r_d    = '0;
      sw_c_d    = '0;
      sw_base_d = '0;
      cnt_d     = '0;
      rc_pend_d = 1'b0;
    end
  end

  // Output register
  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    if (load_out) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      sw_r_q    <= '0;
      sw_c_q    <= '0;
      sw_base_q <= '0;
      nbr_q     <= '0;
      n_pend_q  <= 1'b0;
      rc_pend_q <= 1'b0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      sw_r_q    <= sw_r_d;
      sw_c_q    <= sw_c_d;
      sw_base_q <= sw_base_d;
      nbr_q     <= nbr_d;
      n_pend_q  <= n_pend_d;
      rc_pend_q <= rc_pend_d;
      cnt_q     <= cnt_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      kind_q <= s_axis_tuser_i[0];
      row_q  <= s_axis_tdata_i[15:0];
      col_q  <= s_axis_tdata_i[31:16];
      val_q  <= s_axis_tdata_i[39:32];
    end
    ctr_addr_q <= ctr_addr_d;
    inr_q      <= inr_d;
    cls_q      <= cls_d;
    front_q    <= front_d;
    if (load_out) begin
      out_q <= {3'b000, cnt_sat, front_q, cls_q, inr_q};
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // Store is written only by the clearing pass or a write item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_CDAT))
    else $error("RAM write outside clear or write step");

  // A finished clearing pass leaves every cell in use counted as unknown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sw_last && !evt.size_wr) |=>
      cnt_q == CNT_W'(32'(regs.rows) * 32'(regs.cols)))
    else $error("unknown count wrong after clearing pass");

  // Neighbors are scanned only around a free center
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NBR) |-> (cls_q == CLS_FREE && inr_q))
    else $error("neighbor scan without free in-range center");

  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && ovalid_q) |-> m_axis_tready_i)
    else $error("result overwritten before it was taken");
`endif

endmodule

@@ hw/rtl/ogfc_ram.sv @@
module ogfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ogfc_cfg.sv @@
module ogfc_cfg #(
  parameter int unsigned MAX_ROWS = ogfc_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = ogfc_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ogfc_pkg::APB_AW-1:0]  paddr,
  input  logic [ogfc_pkg::APB_DW-1:0]  pwdata,
  output logic [ogfc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output ogfc_pkg::cfg_regs_t          regs_o,
  output ogfc_pkg::cfg_evt_t           evt_o
);

  import ogfc_pkg::*;

  cfg_regs_t regs_q, regs_d;
  reg_idx_e  idx;
  logic      wr;

  // Size clamp to 1..max
  function automatic logic [SZ_W-1:0] clamp_sz(logic [SZ_W-1:0] v, int unsigned maxv);
    logic [SZ_W-1:0] r;
    if (v == '0) begin
      r = SZ_W'(1);
    end else if (CMP_W'(v) > CMP_W'(maxv)) begin
      r = SZ_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Register writes
  always_comb begin
    regs_d        = regs_q;
    evt_o.size_wr = 1'b0;
    evt_o.th_wr   = 1'b0;
    if (wr) begin
      case (idx)
        REG_ROWS: begin
          regs_d.rows   = clamp_sz(pwdata[SZ_W-1:0], MAX_ROWS);
          evt_o.size_wr = 1'b1;
        end
        REG_COLS: begin
          regs_d.cols   = clamp_sz(pwdata[SZ_W-1:0], MAX_COLS);
          evt_o.size_wr = 1'b1;
        end
        REG_FREE: begin
          regs_d.free_th = pwdata[TH_W-1:0];
          evt_o.th_wr    = 1'b1;
        end
        REG_OCC: begin
          regs_d.occ_th = pwdata[TH_W-1:0];
          evt_o.th_wr   = 1'b1;
        end
        default: begin
          regs_d = regs_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.rows    <= DEF_ROWS;
      regs_q.cols    <= DEF_COLS;
      regs_q.free_th <= DEF_FREE;
      regs_q.occ_th  <= DEF_OCC;
    end else begin
      regs_q <= regs_d;
    end
  end

  // Readback
  always_comb begin
    case (idx)
      REG_ROWS: prdata = APB_DW'(regs_q.rows);
      REG_COLS: prdata = APB_DW'(regs_q.cols);
      REG_FREE: prdata = APB_DW'(regs_q.free_th);
      REG_OCC:  prdata = APB_DW'(regs_q.occ_th);
      default:  prdata = '0;
    endcase
  end

  assign regs_o = regs_q;

endmodule

@@ hw/rtl/ogfc_nbr_unit.sv @@
module ogfc_nbr_unit #(
  parameter int unsigned MAX_ROWS = ogfc_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = ogfc_pkg::MAX_COLS_DEF,
  localparam int unsigned ROW_W = $clog2(MAX_ROWS),
  localparam int unsigned COL_W = $clog2(MAX_COLS),
  localparam int unsigned AW    = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic [AW-1:0]             ctr_addr_i,
  input  logic [ROW_W-1:0]          row_i,
  input  logic [COL_W-1:0]          col_i,
  input  logic [ogfc_pkg::SZ_W-1:0] rows_i,
  input  logic [ogfc_pkg::SZ_W-1:0] cols_i,
  input  logic [2:0]                k_i,
  output logic [AW-1:0]             addr_o,
  output logic                      ok_o
);

  import ogfc_pkg::*;

  step_e         rs, cs;
  logic          row_ok, col_ok;
  logic [AW-1:0] off_r, off_c;

  assign rs = nbr_row_step(k_i);
  assign cs = nbr_col_step(k_i);

  // Bounds of the neighbor; the center is known to be in the grid
  always_comb begin
    row_ok = 1'b1;
    col_ok = 1'b1;
    off_r  = '0;
    off_c  = '0;
    case (rs)
      STEP_DEC: begin
        row_ok = (row_i != '0);
        off_r  = AW'(0) - AW'(MAX_COLS);
      end
      STEP_INC: begin
        row_ok = (CMP_W'(row_i) + CMP_W'(1)) != CMP_W'(rows_i);
        off_r  = AW'(MAX_COLS);
      end
      default: begin
        row_ok = 1'b1;
      end
    endcase
    case (cs)
      STEP_DEC: begin
        col_ok = (col_i != '0);
        off_c  = '1;
      end
      STEP_INC: begin
        col_ok = (CMP_W'(col_i) + CMP_W'(1)) != CMP_W'(cols_i);
        off_c  = AW'(1);
      end
      default: begin
        col_ok = 1'b1;
      end
    endcase
  end

  assign ok_o   = row_ok & col_ok;
  assign addr_o = ctr_addr_i + off_r + off_c;

endmodule

@@ tb/sv/occupancy_grid_frontier_check_test.sv @@
module occupancy_grid_frontier_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ogfc_pkg::*;

  localparam int unsigned GRID_CELLS  = MAX_ROWS_DEF * MAX_COLS_DEF;
  // no beat on any port for this long ends the run (it outlasts a full clear or recount)
  localparam int unsigned STALL_LIMIT = 300000;

  typedef struct {
    logic             in_range;
    cls_e             cell_class;
    logic             is_frontier;
    logic [16:0]      unknown_count;
  } cell_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_valid = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic [0:0]              s_tuser = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_ready = 1'b1;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  // predicted block state
  logic [VAL_W-1:0]  occ_mem [0:GRID_CELLS-1];
  int unsigned       used_rows;
  int unsigned       used_cols;
  logic [TH_W-1:0]   free_lim;
  logic [TH_W-1:0]   occ_lim;
  int unsigned       unk_total;

  cell_result_t      cell_result_q[$];
  int unsigned       err_cnt = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       hold_cnt = 0;
  bit                idle_en = 1'b1;

  occupancy_grid_frontier_check u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    // row[15:0], col[31:16], cell_value[39:32]
    .s_axis_tdata_i  (s_tdata),
    // kind[0]
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // in_range[0], cell_class[2:1], is_frontier[3], unknown_count[20:4], zero[23:21]
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic cls_e cell_class_of(logic [VAL_W-1:0] v);
    if (v == NO_DATA) return CLS_UNK;
    if (v < {1'b0, free_lim}) return CLS_FREE;
    if (v > {1'b0, occ_lim}) return CLS_OCC;
    return CLS_UNK;
  endfunction

  function automatic bit cell_in_grid(int r, int c);
    return r >= 0 && c >= 0 && r < int'(used_rows) && c < int'(used_cols);
  endfunction

  function automatic int unsigned clamp_size(logic [SZ_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (32'(v) > top) return top;
    return 32'(v);
  endfunction

  function automatic void wipe_grid();
    foreach (occ_mem[i]) occ_mem[i] = NO_DATA;
    unk_total = used_rows * used_cols;
  endfunction

  function automatic void recount_unknown();
    unk_total = 0;
    for (int r = 0; r < int'(used_rows); r++)
      for (int c = 0; c < int'(used_cols); c++)
        if (cell_class_of(occ_mem[r * MAX_COLS_DEF + c]) == CLS_UNK) unk_total++;
  endfunction

  function automatic void apply_reg_write(reg_idx_e idx, logic [APB_DW-1:0] data);
    case (idx)
      REG_ROWS: begin
        used_rows = clamp_size(data[SZ_W-1:0], MAX_ROWS_DEF);
        wipe_grid();
      end
      REG_COLS: begin
        used_cols = clamp_size(data[SZ_W-1:0], MAX_COLS_DEF);
        wipe_grid();
      end
      REG_FREE: begin
        free_lim = data[TH_W-1:0];
        recount_unknown();
      end
      REG_OCC: begin
        occ_lim = data[TH_W-1:0];
        recount_unknown();
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted item and queue the result it must produce
  function automatic void predict_cell_result(logic kind, logic [15:0] row,
                                              logic [15:0] col, logic [VAL_W-1:0] val);
    int r;
    int c;
    int idx;
    bit inr;
    cell_result_t res;
    r = int'($signed(row));
    c = int'($signed(col));
    inr = cell_in_grid(r, c);
    idx = r * MAX_COLS_DEF + c;
    if (kind == KIND_WRITE && inr) begin
      if (cell_class_of(occ_mem[idx]) == CLS_UNK) unk_total--;
      occ_mem[idx] = val;
      if (cell_class_of(val) == CLS_UNK) unk_total++;
    end
    res.in_range = inr;
    res.cell_class = CLS_UNK;
    res.is_frontier = 1'b0;
    if (inr) begin
      res.cell_class = cell_class_of(occ_mem[idx]);
      if (res.cell_class == CLS_FREE) begin
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if ((dr != 0 || dc != 0) && cell_in_grid(r + dr, c + dc) &&
                cell_class_of(occ_mem[(r + dr) * MAX_COLS_DEF + c + dc]) == CLS_UNK)
              res.is_frontier = 1'b1;
      end
    end
    res.unknown_count = (unk_total > 32'h1FFFF) ? 17'h1FFFF : unk_total[16:0];
    cell_result_q.insert(cell_result_q.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input beat; tvalid stays high afterwards unless a gap or a drain lowers it
  task automatic send_cell_beat(logic kind, logic [15:0] row, logic [15:0] col,
                                logic [VAL_W-1:0] val);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {val, col, row};
    s_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_cell_result(kind, row, col, val);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_grid_idle();
    s_valid <= 1'b0;
    while (cell_result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // APB write: setup, access, then an idle phase; unused upper bits get junk
  task automatic write_reg(reg_idx_e idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    logic [APB_DW-1:0] data;
    mask = (idx == REG_ROWS || idx == REG_COLS) ? 32'h1FF : 32'h7F;
    data = (32'($urandom()) & ~mask) | (value & mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_reg_write(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_grid(int unsigned rows, int unsigned cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  task automatic set_thresholds(int unsigned free_v, int unsigned occ_v);
    write_reg(REG_FREE, free_v);
    write_reg(REG_OCC, occ_v);
  endtask

  // Coordinate biased toward the grid in use and its edges
  function automatic logic [15:0] pick_coord(int unsigned lim);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return 16'($urandom_range(0, lim - 1));
    if (sel < 15) return 16'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
    if (sel == 15) return 16'(lim - 1);
    if (sel == 16) return 16'(lim);
    if (sel == 17) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  // Cell value biased toward the thresholds and the no-data code
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      5:       return NO_DATA;
      6:       return 8'($urandom_range(101, 254));
      7:       return 8'(free_lim) + 8'($urandom_range(0, 2)) - 8'd1;
      8:       return 8'(occ_lim) + 8'($urandom_range(0, 1));
      9:       return 8'($urandom());
      default: return 8'($urandom_range(0, 100));
    endcase
  endfunction

  // Random items; now and then a 3x3 patch around a cell and a query of its center
  task automatic run_random_items(int n);
    int sent;
    logic [15:0] r0;
    logic [15:0] c0;
    logic kind;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        r0 = 16'($urandom_range(0, used_rows - 1));
        c0 = 16'($urandom_range(0, used_cols - 1));
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            send_cell_beat(KIND_WRITE, r0 + 16'(dr), c0 + 16'(dc),
                           ($urandom_range(0, 7) == 0) ? pick_value()
                                                       : 8'($urandom_range(0, 19)));
        send_cell_beat(KIND_QUERY, r0, c0, 8'($urandom()));
        sent += 10;
      end else begin
        kind = ($urandom_range(0, 99) < 45) ? KIND_QUERY : KIND_WRITE;
        send_cell_beat(kind, pick_coord(used_rows), pick_coord(used_cols), pick_value());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset grid: classes at the thresholds, frontier cases, out-of-range beats
  task automatic test_default_grid();
    send_cell_beat(KIND_QUERY, 16'd0, 16'd0, 8'd0);
    send_cell_beat(KIND_WRITE, 16'd0, 16'd0, 8'd0);
    // free 3x3 block: the center has no unknown neighbor, a corner does
    for (int r = 4; r <= 6; r++)
      for (int c = 4; c <= 6; c++)
        send_cell_beat(KIND_WRITE, 16'(r), 16'(c), 8'd5);
    send_cell_beat(KIND_QUERY, 16'd5, 16'd5, 8'hFF);
    send_cell_beat(KIND_QUERY, 16'd4, 16'd4, 8'h00);
    send_cell_beat(KIND_WRITE, 16'd19, 16'd19, 8'd100);
    send_cell_beat(KIND_WRITE, 16'd19, 16'd18, 8'd80);
    send_cell_beat(KIND_WRITE, 16'd18, 16'd19, 8'd20);
    send_cell_beat(KIND_WRITE, 16'd10, 16'd10, 8'd19);
    send_cell_beat(KIND_WRITE, 16'd10, 16'd10, NO_DATA);
    send_cell_beat(KIND_WRITE, 16'd3, 16'd3, 8'd200);
    send_cell_beat(KIND_WRITE, 16'd19, 16'd0, 8'd101);
    send_cell_beat(KIND_WRITE, 16'hFFFF, 16'd0, 8'd0);
    send_cell_beat(KIND_WRITE, 16'd20, 16'd0, 8'd0);
    send_cell_beat(KIND_QUERY, 16'd0, 16'h8000, 8'd0);
    send_cell_beat(KIND_QUERY, 16'h7FFF, 16'h7FFF, 8'd0);
    send_cell_beat(KIND_QUERY, 16'd0, 16'd20, 8'd0);
    send_cell_beat(KIND_QUERY, 16'h8000, 16'hFFFF, 8'd0);
    wait_grid_idle();
  endtask

  // Threshold settings at and beyond the extremes; each write recounts the grid
  task automatic test_threshold_sweep();
    set_thresholds(0, 100);
    run_random_items(40);
    wait_grid_idle();
    set_thresholds(100, 0);
    run_random_items(40);
    wait_grid_idle();
    set_thresholds(127, 127);
    run_random_items(40);
    wait_grid_idle();
    set_thresholds(20, 80);
    run_random_items(40);
    wait_grid_idle();
  endtask

  // Grid sizes from 1x1 to the full store, including clamped register values
  task automatic test_grid_sizes();
    set_grid(1, 1);
    run_random_items(15);
    wait_grid_idle();
    set_grid(0, 2);
    run_random_items(15);
    wait_grid_idle();
    set_grid(511, 3);
    run_random_items(30);
    wait_grid_idle();
    set_grid(2, 256);
    run_random_items(30);
    wait_grid_idle();
    set_grid(256, 256);
    run_random_items(20);
    wait_grid_idle();
    write_reg(REG_FREE, $urandom_range(10, 60));
    run_random_items(20);
    wait_grid_idle();
    repeat (3) begin
      set_grid($urandom_range(1, 16), $urandom_range(1, 16));
      run_random_items(25);
      wait_grid_idle();
    end
  endtask

  // Last stretch at full rate on both sides
  task automatic test_full_rate();
    idle_en = 1'b0;
    set_thresholds($urandom_range(0, 100), $urandom_range(0, 100));
    set_grid(12, 9);
    run_random_items(150);
    wait_grid_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    used_rows = 32'(DEF_ROWS);
    used_cols = 32'(DEF_COLS);
    free_lim = DEF_FREE;
    occ_lim = DEF_OCC;
    wipe_grid();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_grid();
    run_random_items(120);
    wait_grid_idle();
    test_threshold_sweep();
    test_grid_sizes();
    test_full_rate();
    err_cnt += cell_result_q.size();
    if (err_cnt == 0) begin
      $display("occupancy_grid_frontier_check_test: clean");
    end else begin
      $display("occupancy_grid_frontier_check_test: errors");
    end
    $finish;
  end

  // Result sink stalls in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cnt != 0) begin
        hold_cnt--;
        if (hold_cnt == 0) m_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        hold_cnt = $urandom_range(1, 17);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    cell_result_t want;
    cell_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.in_range = m_axis_tdata_o[0];
      got.cell_class = cls_e'(m_axis_tdata_o[2:1]);
      got.is_frontier = m_axis_tdata_o[3];
      got.unknown_count = m_axis_tdata_o[20:4];
      if (cell_result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("result beat with nothing pending: %h", m_axis_tdata_o);
      end else begin
        want = cell_result_q.pop_front();
        if (got.in_range !== want.in_range || got.cell_class !== want.cell_class ||
            got.is_frontier !== want.is_frontier ||
            got.unknown_count !== want.unknown_count) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result mismatch: in_range %0d/%0d class %0d/%0d frontier %0d/%0d %s",
                     want.in_range, got.in_range, want.cell_class, got.cell_class,
                     want.is_frontier, got.is_frontier,
                     $sformatf("unknown %0d/%0d (expected/actual)",
                               want.unknown_count, got.unknown_count));
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("occupancy_grid_frontier_check_test: errors");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
hw/rtl/ogfc_pkg.sv
hw/rtl/ogfc_ram.sv
hw/rtl/ogfc_cfg.sv
hw/rtl/ogfc_nbr_unit.sv
hw/rtl/occupancy_grid_frontier_check.sv
tb/sv/occupancy_grid_frontier_check_test.sv
